// File: rtl/core/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and constants for the VarInt packet deframer.
// ----------------------------------------------------------------------------
package vpd_pkg;

   localparam logic [31:0] MAX_PACKET_LEN   = 32'd2097151;
   localparam logic [31:0] MAX_INFLATED_LEN = 32'd8388608;

   typedef enum logic [2:0] {
      PH_LEN   = 3'd0,
      PH_DLEN  = 3'd1,
      PH_ID    = 3'd2,
      PH_BODY  = 3'd3,
      PH_ZBODY = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BODY   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_PACKET_LEN = 2'd0,
      ERR_DATA_LEN   = 2'd1,
      ERR_PACKET_ID  = 2'd2
   } error_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] packet_id;
      logic [20:0]        body_length;
      logic [23:0]        inflated_length;
      logic               is_compressed;
      logic [7:0]         body_byte;
      logic               last;
      error_type          error_code;
   } result_type;

endpackage

// File: rtl/core/vpd_parser.sv
// ----------------------------------------------------------------------------
// vpd_parser
// Frame state, VarInt accumulation and per-word result generation.
// ----------------------------------------------------------------------------
module vpd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output logic               push,
   output vpd_pkg::result_type result
);
   import vpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [20:0] bytes_left_ff, bytes_left_in;
   logic        dead_ff, dead_in;
   logic        compression_ff, compression_in;

   logic [31:0] shifted;
   logic [31:0] acc_next;
   logic        done;
   logic        overlong;
   logic [20:0] bl_dec;
   logic        bl_zero;
   logic        len_bad;
   logic        dlen_bad;
   logic        len_zero;
   logic        infl_zero;
   logic        active;

   always_comb begin
      case (cnt_ff)
         3'd0:    shifted = {25'd0, rx_byte[6:0]};
         3'd1:    shifted = {18'd0, rx_byte[6:0], 7'd0};
         3'd2:    shifted = {11'd0, rx_byte[6:0], 14'd0};
         3'd3:    shifted = {4'd0, rx_byte[6:0], 21'd0};
         3'd4:    shifted = {rx_byte[3:0], 28'd0};
         default: shifted = 32'd0;
      endcase
      acc_next  = acc_ff | shifted;
      done      = !rx_byte[7];
      overlong  = rx_byte[7] && (cnt_ff == 3'd4);
      bl_dec    = bytes_left_ff - 21'd1;
      bl_zero   = (bl_dec == 21'd0);
      len_bad   = (acc_next > MAX_PACKET_LEN);
      dlen_bad  = (acc_next > MAX_INFLATED_LEN);
      len_zero  = (acc_next[20:0] == 21'd0);
      infl_zero = (acc_next[23:0] == 24'd0);
      active    = accept && !dead_ff;
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      bytes_left_in  = bytes_left_ff;
      dead_in        = dead_ff;
      compression_in = csr_wr_en ? csr_wr_data : compression_ff;
      if (active) begin
         case (phase_ff)
            PH_LEN: begin
               acc_in = acc_next;
               cnt_in = cnt_ff + 3'd1;
               if (!done) begin
                  if (overlong) dead_in = 1'b1;
               end else if (len_bad || len_zero) begin
                  dead_in = 1'b1;
               end else begin
                  acc_in        = 32'd0;
                  cnt_in        = 3'd0;
                  bytes_left_in = acc_next[20:0];
                  phase_in      = compression_ff ? PH_DLEN : PH_ID;
               end
            end
            PH_DLEN: begin
               acc_in        = acc_next;
               cnt_in        = cnt_ff + 3'd1;
               bytes_left_in = bl_dec;
               if (!done) begin
                  if (overlong || bl_zero) dead_in = 1'b1;
               end else if (dlen_bad || (infl_zero && bl_zero)) begin
                  dead_in = 1'b1;
               end else begin
                  acc_in = 32'd0;
                  cnt_in = 3'd0;
                  if (infl_zero) begin
                     phase_in = PH_ID;
                  end else begin
                     phase_in = bl_zero ? PH_LEN : PH_ZBODY;
                  end
               end
            end
            PH_ID: begin
               acc_in        = acc_next;
               cnt_in        = cnt_ff + 3'd1;
               bytes_left_in = bl_dec;
               if (!done) begin
                  if (overlong || bl_zero) dead_in = 1'b1;
               end else begin
                  acc_in   = 32'd0;
                  cnt_in   = 3'd0;
                  phase_in = bl_zero ? PH_LEN : PH_BODY;
               end
            end
            PH_BODY, PH_ZBODY: begin
               bytes_left_in = bl_dec;
               if (bl_zero) phase_in = PH_LEN;
            end
            default: begin
               phase_in = PH_LEN;
               acc_in   = 32'd0;
               cnt_in   = 3'd0;
            end
         endcase
      end
   end

   // result
   always_comb begin
      push   = 1'b0;
      result = '0;
      if (active) begin
         case (phase_ff)
            PH_LEN: begin
               if ((!done && overlong) || (done && len_bad)) begin
                  push              = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_PACKET_LEN;
               end else if (done && len_zero) begin
                  push              = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = compression_ff ? ERR_DATA_LEN : ERR_PACKET_ID;
               end
            end
            PH_DLEN: begin
               if ((!done && (overlong || bl_zero)) || (done && dlen_bad)) begin
                  push              = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_DATA_LEN;
               end else if (done && infl_zero && bl_zero) begin
                  push              = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_PACKET_ID;
               end else if (done && !infl_zero) begin
                  push                   = 1'b1;
                  result.kind            = KIND_HEADER;
                  result.body_length     = bl_dec;
                  result.inflated_length = acc_next[23:0];
                  result.is_compressed   = 1'b1;
                  result.last            = bl_zero;
               end
            end
            PH_ID: begin
               if (!done && (overlong || bl_zero)) begin
                  push              = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_PACKET_ID;
               end else if (done) begin
                  push               = 1'b1;
                  result.kind        = KIND_HEADER;
                  result.packet_id   = acc_next;
                  result.body_length = bl_dec;
                  result.last        = bl_zero;
               end
            end
            PH_BODY, PH_ZBODY: begin
               push                 = 1'b1;
               result.kind          = KIND_BODY;
               result.is_compressed = (phase_ff == PH_ZBODY);
               result.body_byte     = rx_byte;
               result.last          = bl_zero;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN;
         acc_ff         <= 32'd0;
         cnt_ff         <= 3'd0;
         bytes_left_ff  <= 21'd0;
         dead_ff        <= 1'b0;
         compression_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         bytes_left_ff  <= bytes_left_in;
         dead_ff        <= dead_in;
         compression_ff <= compression_in;
      end
   end

   a_error_kills: assert property (@(posedge clock) disable iff (reset)
      (push && result.kind == KIND_ERROR) |=> dead_ff)
      else $error("error word did not stop the parser");

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      dead_ff |-> !push)
      else $error("word emitted after error");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      (push && result.kind == KIND_HEADER) |-> (result.last == (result.body_length == 21'd0)))
      else $error("header last flag disagrees with body length");

endmodule

// File: rtl/core/vpd_out_buf.sv
// ----------------------------------------------------------------------------
// vpd_out_buf
// Result register with one skid entry; stall toward the parser is registered.
// ----------------------------------------------------------------------------
module vpd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vpd_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vpd_pkg::result_type rsp_data
);
   import vpd_pkg::*;

   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       pop;

   always_comb begin
      pop           = head_valid_ff && !rsp_stall;
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without head entry");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("word pushed into full buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (head_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to head on pop");

endmodule

// File: rtl/core/varint_packet_deframer.sv
// ----------------------------------------------------------------------------
// varint_packet_deframer
// Splits a decrypted byte stream into VarInt-framed packets: headers, body
// words with a last flag, and a terminal error word.
// ----------------------------------------------------------------------------
// Output: a result word is registered in the output buffer before it is valid on rsp_.
// Throughput: one byte per cycle while req_stall is low; the parser state updates in the accept cycle.
// req_stall rises only when both output entries hold words not yet taken.
// Reset: synchronous; clears frame state, error lock and compression mode.
module varint_packet_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_packet_id,
   output logic [20:0]        rsp_body_length,
   output logic [23:0]        rsp_inflated_length,
   output logic               rsp_is_compressed,
   output logic [7:0]         rsp_body_byte,
   output logic               rsp_last,
   output logic [1:0]         rsp_error_code
);
   import vpd_pkg::*;

   logic       accept;
   logic       push;
   logic       full;
   result_type push_data;
   result_type rsp_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   vpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .result      (push_data)
   );

   vpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_packet_id       = rsp_data.packet_id;
   assign rsp_body_length     = rsp_data.body_length;
   assign rsp_inflated_length = rsp_data.inflated_length;
   assign rsp_is_compressed   = rsp_data.is_compressed;
   assign rsp_body_byte       = rsp_data.body_byte;
   assign rsp_last            = rsp_data.last;
   assign rsp_error_code      = rsp_data.error_code;

endmodule

// File: test/varint_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_packet_deframer_tb
// Feeds VarInt-framed packets into the deframer with random gaps on the
// request side and random stalls on the response side. Plain and compressed
// frames are sent, with and without compression mode. Each response word is
// compared field by field against a software deframer that is updated on
// every accepted byte. The run begins with a table of directed frames, moves
// on to random frames in several compression phases, and ends with one
// framing error picked at random, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module varint_packet_deframer_tb;
   import vpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      bit          comp;
      logic [31:0] id;
      logic [7:0]  body_len;
      logic [23:0] inflated;
      bit          padded;
      bit          typed;
      logic [31:0] exp_id;
      logic [20:0] exp_len;
      logic [23:0] exp_infl;
      bit          exp_zip;
      bit          exp_last;
   } frame_spec;

   typedef struct packed {
      bit              comp;
      logic [2:0]      count;
      logic [0:5][7:0] seq;
      error_type       code;
   } fault_spec;

   // comp, id, body, inflated, padded, typed | id, length, inflated, zip, last
   localparam frame_spec DIRECTED [0:13] = '{
      '{1'b0, 32'h0000_0000, 8'd0,   24'd0,        1'b0, 1'b1,
        32'h0000_0000, 21'd0, 24'd0,        1'b0, 1'b1},
      '{1'b0, 32'h0000_007F, 8'd3,   24'd0,        1'b0, 1'b1,
        32'h0000_007F, 21'd3, 24'd0,        1'b0, 1'b0},
      '{1'b0, 32'h0000_0080, 8'd1,   24'd0,        1'b0, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0},
      '{1'b0, 32'h7FFF_FFFF, 8'd0,   24'd0,        1'b0, 1'b1,
        32'h7FFF_FFFF, 21'd0, 24'd0,        1'b0, 1'b1},
      '{1'b0, 32'h8000_0000, 8'd2,   24'd0,        1'b0, 1'b1,
        32'h8000_0000, 21'd2, 24'd0,        1'b0, 1'b0},
      '{1'b0, 32'hFFFF_FFFF, 8'd0,   24'd0,        1'b1, 1'b1,
        32'hFFFF_FFFF, 21'd0, 24'd0,        1'b0, 1'b1},
      '{1'b0, 32'h0000_012C, 8'd126, 24'd0,        1'b1, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0000, 8'd0,   24'd0,        1'b0, 1'b1,
        32'h0000_0000, 21'd0, 24'd0,        1'b0, 1'b1},
      '{1'b1, 32'h0000_1234, 8'd4,   24'd0,        1'b1, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0},
      '{1'b1, 32'h0000_0000, 8'd0,   24'd1,        1'b0, 1'b1,
        32'h0000_0000, 21'd0, 24'd1,        1'b1, 1'b1},
      '{1'b1, 32'h0000_0000, 8'd5,   24'h80_0000,  1'b0, 1'b1,
        32'h0000_0000, 21'd5, 24'h80_0000,  1'b1, 1'b0},
      '{1'b1, 32'h0000_0000, 8'd9,   24'd200,      1'b1, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0},
      '{1'b0, 32'hFFFF_FFFE, 8'd6,   24'd0,        1'b1, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0},
      '{1'b1, 32'h1000_0000, 8'd1,   24'd0,        1'b0, 1'b0,
        32'h0, 21'd0, 24'd0, 1'b0, 1'b0}
   };

   // Terminal framing errors; one is picked per run.
   localparam fault_spec FAULTS [0:12] = '{
      '{1'b0, 3'd5, 48'h80_80_80_80_80_00, ERR_PACKET_LEN},  // overlong length
      '{1'b0, 3'd4, 48'h80_80_80_01_00_00, ERR_PACKET_LEN},  // length above max
      '{1'b1, 3'd5, 48'hFF_FF_FF_FF_0F_00, ERR_PACKET_LEN},  // negative length
      '{1'b1, 3'd1, 48'h00_00_00_00_00_00, ERR_DATA_LEN},    // empty packet
      '{1'b0, 3'd1, 48'h00_00_00_00_00_00, ERR_PACKET_ID},   // empty packet
      '{1'b1, 3'd6, 48'h06_80_80_80_80_80, ERR_DATA_LEN},    // overlong data length
      '{1'b1, 3'd5, 48'h04_81_80_80_04_00, ERR_DATA_LEN},    // data length above max
      '{1'b1, 3'd6, 48'h06_FF_FF_FF_FF_0F, ERR_DATA_LEN},    // negative data length
      '{1'b1, 3'd3, 48'h02_80_80_00_00_00, ERR_DATA_LEN},    // data length overrun
      '{1'b1, 3'd2, 48'h01_00_00_00_00_00, ERR_PACKET_ID},   // data length only
      '{1'b0, 3'd2, 48'h01_80_00_00_00_00, ERR_PACKET_ID},   // id overrun
      '{1'b0, 3'd6, 48'h06_80_80_80_80_80, ERR_PACKET_ID},   // overlong id
      '{1'b1, 3'd4, 48'h03_00_80_80_00_00, ERR_PACKET_ID}    // id overrun, compressed mode
   };

   logic               clock;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic               csr_wr_data = 1'b0;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_packet_id;
   logic [20:0]        rsp_body_length;
   logic [23:0]        rsp_inflated_length;
   logic               rsp_is_compressed;
   logic [7:0]         rsp_body_byte;
   logic               rsp_last;
   logic [1:0]         rsp_error_code;

   varint_packet_deframer dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_packet_id       (rsp_packet_id),
      .rsp_body_length     (rsp_body_length),
      .rsp_inflated_length (rsp_inflated_length),
      .rsp_is_compressed   (rsp_is_compressed),
      .rsp_body_byte       (rsp_body_byte),
      .rsp_last            (rsp_last),
      .rsp_error_code      (rsp_error_code)
   );

   // Software deframer state
   phase_type   parse_phase = PH_LEN;
   logic [31:0] vint_value  = '0;
   logic [2:0]  vint_count  = '0;
   logic [20:0] bytes_left  = '0;
   logic [23:0] inflate_len = '0;
   bit          locked      = 1'b0;
   bit          comp_mode   = 1'b0;

   result_type  expected_words [$];
   result_type  typed_word;
   bit          typed_pending = 1'b0;

   int idle_pct       = 35;
   int cycle_count    = 0;
   int fail_count     = 0;
   int bytes_sent     = 0;
   int frames_sent    = 0;
   int config_writes  = 0;
   int words_checked  = 0;
   int headers_seen   = 0;
   int body_seen      = 0;
   int fault_pick     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t ns: timeout, %0d words still pending", $time, expected_words.size());
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) rsp_stall <= !reset && ($urandom_range(99) < idle_pct);

   function automatic void restart_varint();
      vint_value = '0;
      vint_count = '0;
   endfunction

   // Folds one byte into the VarInt being read; returns 1 on its final byte.
   function automatic bit take_group(input logic [7:0] b);
      if (7 * vint_count < 32)
         vint_value = vint_value | (32'(b[6:0]) << (7 * vint_count));
      vint_count = vint_count + 3'd1;
      return !b[7];
   endfunction

   function automatic bit fail_word(output result_type w, input error_type code);
      w            = '0;
      w.kind       = KIND_ERROR;
      w.error_code = code;
      locked       = 1'b1;
      restart_varint();
      return 1'b1;
   endfunction

   // Advances the deframer by one byte; returns 1 when a word is produced.
   function automatic bit deframe_byte(input logic [7:0] b, output result_type w);
      bit ended;
      w = '0;
      if (locked)
         return 1'b0;
      case (parse_phase)
         PH_LEN: begin
            ended = take_group(b);
            if (!ended) begin
               if (vint_count >= 3'd5)
                  return fail_word(w, ERR_PACKET_LEN);
               return 1'b0;
            end
            if (vint_value > MAX_PACKET_LEN)
               return fail_word(w, ERR_PACKET_LEN);
            bytes_left = vint_value[20:0];
            restart_varint();
            if (bytes_left == 0)
               return fail_word(w, comp_mode ? ERR_DATA_LEN : ERR_PACKET_ID);
            parse_phase = comp_mode ? PH_DLEN : PH_ID;
            return 1'b0;
         end
         PH_DLEN: begin
            ended      = take_group(b);
            bytes_left = bytes_left - 21'd1;
            if (!ended) begin
               if (vint_count >= 3'd5 || bytes_left == 0)
                  return fail_word(w, ERR_DATA_LEN);
               return 1'b0;
            end
            if (vint_value > MAX_INFLATED_LEN)
               return fail_word(w, ERR_DATA_LEN);
            inflate_len = vint_value[23:0];
            restart_varint();
            if (inflate_len == 0) begin
               if (bytes_left == 0)
                  return fail_word(w, ERR_PACKET_ID);
               parse_phase = PH_ID;
               return 1'b0;
            end
            w.kind            = KIND_HEADER;
            w.body_length     = bytes_left;
            w.inflated_length = inflate_len;
            w.is_compressed   = 1'b1;
            w.last            = (bytes_left == 0);
            parse_phase       = (bytes_left == 0) ? PH_LEN : PH_ZBODY;
            return 1'b1;
         end
         PH_ID: begin
            ended      = take_group(b);
            bytes_left = bytes_left - 21'd1;
            if (!ended) begin
               if (vint_count >= 3'd5 || bytes_left == 0)
                  return fail_word(w, ERR_PACKET_ID);
               return 1'b0;
            end
            w.kind        = KIND_HEADER;
            w.packet_id   = vint_value;
            w.body_length = bytes_left;
            w.last        = (bytes_left == 0);
            restart_varint();
            inflate_len   = '0;
            parse_phase   = (bytes_left == 0) ? PH_LEN : PH_BODY;
            return 1'b1;
         end
         PH_BODY, PH_ZBODY: begin
            bytes_left      = bytes_left - 21'd1;
            w.kind          = KIND_BODY;
            w.is_compressed = (parse_phase == PH_ZBODY);
            w.body_byte     = b;
            w.last          = (bytes_left == 0);
            if (bytes_left == 0) begin
               parse_phase = PH_LEN;
               restart_varint();
            end
            return 1'b1;
         end
         default: begin
            parse_phase = PH_LEN;
            restart_varint();
            return 1'b0;
         end
      endcase
   endfunction

   // Appends a VarInt, optionally stretched with redundant continuation bytes.
   function automatic void append_varint(ref logic [7:0] q[$], input logic [31:0] v,
                                         input bit padded);
      int         groups;
      int         total;
      logic [7:0] cur;
      groups = 1;
      while (groups < 5 && (v >> (7 * groups)) != 0)
         groups++;
      total = padded ? $urandom_range(5, groups) : groups;
      for (int i = 0; i < total; i++) begin
         cur = 8'((v >> (7 * i)) & 32'h7F);
         if (i == 4)
            cur[6:4] = 3'($urandom_range(7));
         cur[7] = (i < total - 1);
         q = {q, cur};
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      result_type w;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      bytes_sent++;
      if (deframe_byte(b, w)) begin
         if (typed_pending) begin
            w             = typed_word;
            typed_pending = 1'b0;
         end
         expected_words = {expected_words, w};
      end
   endtask

   task automatic send_frame(input logic [31:0] id, input int body_len,
                             input logic [23:0] inflated, input bit padded);
      logic [7:0] inner [$];
      logic [7:0] frame [$];
      if (inflated != 0) begin
         append_varint(inner, 32'(inflated), padded);
      end else begin
         if (comp_mode)
            append_varint(inner, 32'd0, padded);
         append_varint(inner, id, padded);
      end
      repeat (body_len) inner = {inner, 8'($urandom)};
      append_varint(frame, 32'(inner.size()), padded);
      frame = {frame, inner};
      foreach (frame[i]) send_byte(frame[i]);
      frames_sent++;
   endtask

   task automatic random_frame();
      logic [31:0] id;
      int          body_len;
      logic [23:0] inflated;
      case ($urandom_range(3))
         0:       id = $urandom_range(127);
         1:       id = $urandom_range(16383);
         default: id = $urandom;
      endcase
      body_len = ($urandom_range(9) == 0) ? $urandom_range(150) : $urandom_range(12);
      inflated = '0;
      if (comp_mode && $urandom_range(2) == 0)
         inflated = ($urandom_range(7) == 0) ? 24'(MAX_INFLATED_LEN)
                                             : 24'($urandom_range(8388608, 1));
      send_frame(id, body_len, inflated, $urandom_range(4) == 0);
   endtask

   // Drain all pending words, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_compression(input bit on);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      comp_mode = on;
      config_writes++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Words are sampled mid-cycle; valid and stall are stable until the edge.
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got kind %0d", $time, rsp_kind);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("packet_id", want.packet_id, rsp_packet_id);
            check_field("body_length", want.body_length, rsp_body_length);
            check_field("inflated_length", want.inflated_length, rsp_inflated_length);
            check_field("is_compressed", want.is_compressed, rsp_is_compressed);
            check_field("body_byte", want.body_byte, rsp_body_byte);
            check_field("last", want.last, rsp_last);
            check_field("error_code", want.error_code, rsp_error_code);
            words_checked++;
            if (want.kind == KIND_HEADER)
               headers_seen++;
            else if (want.kind == KIND_BODY)
               body_seen++;
         end
      end
   end

   initial begin
      frame_spec row;
      fault_spec fault;
      int        mark;
      bit        mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.comp != comp_mode)
            set_compression(row.comp);
         if (row.typed) begin
            typed_word                 = '0;
            typed_word.kind            = KIND_HEADER;
            typed_word.packet_id       = row.exp_id;
            typed_word.body_length     = row.exp_len;
            typed_word.inflated_length = row.exp_infl;
            typed_word.is_compressed   = row.exp_zip;
            typed_word.last            = row.exp_last;
            typed_pending              = 1'b1;
         end
         send_frame(row.id, row.body_len, row.inflated, row.padded);
      end

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 3)
            0:       mode = 1'b1;
            1:       mode = 1'b0;
            default: mode = 1'($urandom_range(1));
         endcase
         set_compression(mode);
         idle_pct = (ph == 4) ? 0 : 35;
         mark = bytes_sent;
         while (bytes_sent - mark < 200)
            random_frame();
      end
      idle_pct = 35;

      fault_pick = $urandom_range(12);
      fault      = FAULTS[fault_pick];
      if (fault.comp != comp_mode)
         set_compression(fault.comp);
      else
         settle();
      typed_word            = '0;
      typed_word.kind       = KIND_ERROR;
      typed_word.error_code = fault.code;
      typed_pending         = 1'b1;
      for (int i = 0; i < fault.count; i++)
         send_byte(fault.seq[i]);
      // locked out: everything after the error must be dropped
      repeat (24) send_byte(8'($urandom));
      send_frame(32'd1, 3, 24'd0, 1'b0);

      req_valid <= 1'b0;
      idle_pct = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d frames across %0d compression writes; error case %0d.",
               bytes_sent, frames_sent, config_writes, fault_pick);
      $display("Checked %0d words: %0d headers, %0d body, %0d mismatches.",
               words_checked, headers_seen, body_seen, fail_count);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
